// ===== rtl/core/ple_pkg.sv =====
package ple_pkg;

   localparam int CMD_W    = 4;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = 7;
   localparam int STAT_W   = 2;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 48;
   localparam int REQ_USED = CMD_W + POS_W + DATA_W;
   localparam int RSP_USED = DATA_W + CNT_W + STAT_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND     = 4'd0,
      CMD_PREPEND    = 4'd1,
      CMD_DROP_LAST  = 4'd2,
      CMD_DROP_FIRST = 4'd3,
      CMD_INSERT     = 4'd4,
      CMD_REMOVE     = 4'd5,
      CMD_READ       = 4'd6,
      CMD_WRITE      = 4'd7,
      CMD_CLEAR      = 4'd8
   } cmd_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // what the datapath has to do for an accepted word
   typedef enum logic [2:0] {
      OP_NONE,
      OP_APPEND,
      OP_OPEN,
      OP_CLOSE,
      OP_DROP,
      OP_READ,
      OP_WRITE,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_READ,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic shift;
      logic read;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      op_type op_plan;
      logic   shift_done;
      logic   rsp_busy;
   } ctl_stat_type;

endpackage

// ===== rtl/core/ple_ram.sv =====
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/ple_ctrl.sv =====
module ple_ctrl import ple_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ctl_stat_type ctl_stat,
   output ctl_cmd_type  ctl_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl_cmd    = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl_cmd.accept = 1'b1;
               case (ctl_stat.op_plan)
                  OP_OPEN, OP_CLOSE: state_in = S_SHIFT;
                  OP_READ:           state_in = S_READ;
                  default:           state_in = S_FINISH;
               endcase
            end
         end
         S_SHIFT: begin
            ctl_cmd.shift = 1'b1;
            if (ctl_stat.shift_done) begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            ctl_cmd.read = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            // hold until the result register is free
            if (!ctl_stat.rsp_busy) begin
               ctl_cmd.finish = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/ple_dpath.sv =====
module ple_dpath import ple_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  ctl_cmd_type      ctl_cmd,
   output ctl_stat_type     ctl_stat,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int CntW  = $clog2(CAPACITY + 1);
   localparam int AddrW = $clog2(CAPACITY);
   localparam int CmpW  = (CntW > POS_W) ? CntW : POS_W;

   // request fields
   cmd_code_type              req_command;
   logic [POS_W-1:0]          req_position;
   logic [DATA_W-1:0]         req_data;

   // decode
   op_type                    plan_op;
   status_type                plan_status;
   logic [CntW-1:0]           pos_eff;
   logic [CmpW-1:0]           pos_ext;
   logic [CmpW-1:0]           cnt_ext;
   logic                      is_full;

   // control registers
   logic [CntW-1:0]           count_ff, count_in;
   logic                      pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // work registers
   op_type                    op_ff, op_in;
   status_type                status_ff, status_in;
   logic [AddrW-1:0]          pos_ff, pos_in;
   logic [DATA_W-1:0]         data_ff, data_in;
   logic [AddrW-1:0]          src_ff, src_in;
   logic [CntW-1:0]           left_ff, left_in;
   logic [AddrW-1:0]          wr_addr_ff, wr_addr_in;

   // result registers
   logic [DATA_W-1:0]         rsp_read_data_ff, rsp_read_data_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;
   status_type                rsp_status_ff, rsp_status_in;

   // memory port
   logic                      ram_we;
   logic [AddrW-1:0]          ram_waddr;
   logic [DATA_W-1:0]         ram_wdata;
   logic                      ram_re;
   logic [AddrW-1:0]          ram_raddr;
   logic [DATA_W-1:0]         ram_rdata;

   logic                      shift_up;
   logic                      step;
   logic [CntW-1:0]           count_next;

   assign req_command  = cmd_code_type'(req_tdata[CMD_W-1:0]);
   assign req_position = req_tdata[CMD_W +: POS_W];
   assign req_data     = req_tdata[CMD_W+POS_W +: DATA_W];

   always_comb begin
      pos_ext     = CmpW'(req_position);
      cnt_ext     = CmpW'(count_ff);
      is_full     = (count_ff == CntW'(CAPACITY));
      plan_op     = OP_NONE;
      plan_status = ST_OK;
      pos_eff     = CntW'(req_position);
      case (req_command)
         CMD_APPEND: begin
            if (is_full) plan_status = ST_FULL;
            else         plan_op     = OP_APPEND;
         end
         CMD_PREPEND: begin
            pos_eff = '0;
            if (is_full) plan_status = ST_FULL;
            else         plan_op     = OP_OPEN;
         end
         CMD_DROP_LAST: begin
            if (count_ff == '0) plan_status = ST_RANGE;
            else                plan_op     = OP_DROP;
         end
         CMD_DROP_FIRST: begin
            pos_eff = '0;
            if (count_ff == '0) plan_status = ST_RANGE;
            else                plan_op     = OP_CLOSE;
         end
         CMD_INSERT: begin
            if (is_full)                plan_status = ST_FULL;
            else if (pos_ext > cnt_ext) plan_status = ST_RANGE;
            else                        plan_op     = OP_OPEN;
         end
         CMD_REMOVE: begin
            if (pos_ext >= cnt_ext) plan_status = ST_RANGE;
            else                    plan_op     = OP_CLOSE;
         end
         CMD_READ: begin
            if (pos_ext >= cnt_ext) plan_status = ST_RANGE;
            else                    plan_op     = OP_READ;
         end
         CMD_WRITE: begin
            if (pos_ext >= cnt_ext) plan_status = ST_RANGE;
            else                    plan_op     = OP_WRITE;
         end
         CMD_CLEAR: begin
            plan_op = OP_CLEAR;
         end
         default: begin
            plan_op = OP_NONE;
         end
      endcase
   end

   assign shift_up = (op_ff == OP_OPEN);
   assign step     = ctl_cmd.shift && (left_ff != '0);

   // work registers and shift walk
   always_comb begin
      op_in      = op_ff;
      status_in  = status_ff;
      pos_in     = pos_ff;
      data_in    = data_ff;
      src_in     = src_ff;
      left_in    = left_ff;
      wr_addr_in = wr_addr_ff;
      pend_in    = step;
      if (ctl_cmd.accept) begin
         op_in     = plan_op;
         status_in = plan_status;
         pos_in    = AddrW'(pos_eff);
         data_in   = req_data;
         if (plan_op == OP_CLOSE) begin
            src_in  = AddrW'(pos_eff + CntW'(1));
            left_in = count_ff - pos_eff - CntW'(1);
         end else begin
            src_in  = AddrW'(count_ff - CntW'(1));
            left_in = count_ff - pos_eff;
         end
      end else if (step) begin
         // word read now lands one place up or down in the next cycle
         left_in = left_ff - CntW'(1);
         if (shift_up) begin
            wr_addr_in = src_ff + AddrW'(1);
            src_in     = src_ff - AddrW'(1);
         end else begin
            wr_addr_in = src_ff - AddrW'(1);
            src_in     = src_ff + AddrW'(1);
         end
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wr_addr_ff;
      ram_wdata = ram_rdata;
      if (pend_ff) begin
         ram_we = 1'b1;
      end else if (ctl_cmd.finish) begin
         case (op_ff)
            OP_APPEND: begin
               ram_we    = 1'b1;
               ram_waddr = AddrW'(count_ff);
               ram_wdata = data_ff;
            end
            OP_OPEN, OP_WRITE: begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               ram_wdata = data_ff;
            end
            default: begin
               ram_we = 1'b0;
            end
         endcase
      end
      ram_re    = step || ctl_cmd.read;
      ram_raddr = ctl_cmd.read ? pos_ff : src_ff;
   end

   always_comb begin
      case (op_ff)
         OP_APPEND, OP_OPEN: count_next = count_ff + CntW'(1);
         OP_CLOSE, OP_DROP:  count_next = count_ff - CntW'(1);
         OP_CLEAR:           count_next = '0;
         default:            count_next = count_ff;
      endcase
   end

   always_comb begin
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_status_in    = rsp_status_ff;
      if (ctl_cmd.finish) begin
         count_in         = count_next;
         rsp_valid_in     = 1'b1;
         rsp_read_data_in = (op_ff == OP_READ) ? ram_rdata : '0;
         rsp_count_in     = CNT_W'(count_next);
         rsp_status_in    = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      status_ff        <= status_in;
      pos_ff           <= pos_in;
      data_ff          <= data_in;
      src_ff           <= src_in;
      left_ff          <= left_in;
      wr_addr_ff       <= wr_addr_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_status_ff    <= rsp_status_in;
   end

   ple_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ctl_stat.op_plan    = plan_op;
   assign ctl_stat.shift_done = (left_ff == '0);
   assign ctl_stat.rsp_busy   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - RSP_USED){1'b0}}, rsp_status_ff, rsp_count_ff,
                        rsp_read_data_ff};

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Ordered list of up to CAPACITY signed 32-bit words with positional access.
// A command word enters on the req_ channel; exactly one result word leaves on
// the rsp_ channel for each command, carrying read data (zero unless a read
// succeeds), the element count after the command and a status code
// (ok, list full, or empty list or position out of range). A failing command leaves
// the list unchanged.
// One command is worked on at a time. Append, drop last, write, clear, unknown
// codes and any command that fails go from acceptance straight to the finish
// step; a read passes through a RAM read step first. Insert, prepend, remove and
// drop first move the tail of the list through a single-port-pair RAM, one word
// per cycle, in a shift step before the finish step; at most CAPACITY - 1 entries
// shift. The controller returns to idle as it finishes a command and takes the
// next command from then on.
// The result sits in an output register; the next command may be accepted
// while it waits, but a stalled rsp_tready holds that command's completion
// until the earlier result is taken.
// Reset empties the list and drops any result not yet taken; no clearing
// pass is needed, as only entries below the count are ever read.
module positional_list_engine import ple_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // command[3:0], position[10:4], data[42:11], zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // read_data[31:0], count[38:32], status[40:39], zero pad
);

   ctl_cmd_type  ctl_cmd;
   ctl_stat_type ctl_stat;

   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .ctl_stat   (ctl_stat),
      .ctl_cmd    (ctl_cmd)
   );

   ple_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl_cmd    (ctl_cmd),
      .ctl_stat   (ctl_stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
